### rtl/mexp_pkg.sv
// Shared constants and controller/datapath interface types for the modular exponentiation core.
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 63;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;    // capture operands on input transfer
    logic red_start;  // load lane B for base reduction
    logic mul_start;  // load both lanes for multiply and square
    logic step;       // advance lanes by one bit
    logic red_take;   // store reduced base
    logic mul_take;   // store product and square, shift exponent
    logic res_load;   // move result into output register
  } mexp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_trivial; // exponent zero or modulus at most one
    logic e_last;     // current exponent bit is the top set bit
  } mexp_sts_t;

endpackage

### rtl/mexp_lane.sv
// Bit-serial modular multiply lane (LSB first) and reduce mode (shifts in MSB first).
`timescale 1ns / 1ps

module mexp_lane #(
  parameter int unsigned DataWidth = mexp_pkg::DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic                 red_i,
  input  logic                 step_i,
  input  logic [DataWidth-1:0] x_i,
  input  logic [DataWidth-1:0] y_i,
  input  logic [DataWidth-1:0] m_i,
  output logic [DataWidth-1:0] acc_o
);
  import mexp_pkg::*;

  logic [DataWidth-1:0] acc_q, acc_d;
  logic [DataWidth-1:0] add_q, add_d;
  logic [DataWidth-1:0] y_q, y_d;
  logic                 red_q;
  logic [DataWidth:0]   sum, sum_red, dbl, dbl_red, m_ext;

  always_comb begin
    m_ext = {1'b0, m_i};
    // reduce mode: acc = 2*acc + next bit; multiply mode: acc += addend when bit set
    if (red_q) begin
      sum = {acc_q, y_q[DataWidth-1]};
    end else begin
      sum = {1'b0, acc_q} + (y_q[0] ? {1'b0, add_q} : '0);
    end
    sum_red = (sum >= m_ext) ? sum - m_ext : sum;
    dbl     = {add_q, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    acc_d   = sum_red[DataWidth-1:0];
    add_d   = dbl_red[DataWidth-1:0];
    y_d     = red_q ? {y_q[DataWidth-2:0], 1'b0} : {1'b0, y_q[DataWidth-1:1]};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      acc_q <= '0;
      add_q <= x_i;
      y_q   <= y_i;
      red_q <= red_i;
    end else if (step_i) begin
      acc_q <= acc_d;
      add_q <= add_d;
      y_q   <= y_d;
    end
  end

  assign acc_o = acc_q;

endmodule

### rtl/mexp_dp.sv
// Datapath: operand, exponent and result registers plus two modular multiply lanes.
`timescale 1ns / 1ps

module mexp_dp #(
  parameter int unsigned DataWidth = mexp_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  mexp_pkg::mexp_cmd_t   cmd_i,
  output mexp_pkg::mexp_sts_t   sts_o,
  input  logic [DataWidth-1:0]  base_value_i,
  input  logic [DataWidth-1:0]  exponent_i,
  input  logic [DataWidth-1:0]  modulus_i,
  output logic [DataWidth-1:0]  power_residue_o
);
  import mexp_pkg::*;

  logic [DataWidth-1:0] b_q, e_q, m_q, r_q, res_q;
  logic [DataWidth-1:0] acc_a, acc_b;
  logic                 in_trivial;

  assign in_trivial = (exponent_i == '0) || (modulus_i <= DataWidth'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      b_q <= base_value_i;
      e_q <= exponent_i;
      m_q <= modulus_i;
      // zero exponent gives 1 unreduced; modulus of one (or zero) gives 0
      r_q <= (exponent_i == '0)            ? DataWidth'(1) :
             (modulus_i <= DataWidth'(1))  ? '0 : DataWidth'(1);
    end else if (cmd_i.red_take) begin
      b_q <= acc_b;
    end else if (cmd_i.mul_take) begin
      if (e_q[0]) begin
        r_q <= acc_a;
      end
      b_q <= acc_b;
      e_q <= {1'b0, e_q[DataWidth-1:1]};
    end
    if (cmd_i.res_load) begin
      res_q <= r_q;
    end
  end

  // lane A: r * b
  mexp_lane #(.DataWidth(DataWidth)) u_lane_a (
    .clk_i  (clk_i),
    .load_i (cmd_i.mul_start),
    .red_i  (1'b0),
    .step_i (cmd_i.step),
    .x_i    (r_q),
    .y_i    (b_q),
    .m_i    (m_q),
    .acc_o  (acc_a)
  );

  // lane B: base reduction, then b * b
  mexp_lane #(.DataWidth(DataWidth)) u_lane_b (
    .clk_i  (clk_i),
    .load_i (cmd_i.red_start | cmd_i.mul_start),
    .red_i  (cmd_i.red_start),
    .step_i (cmd_i.step),
    .x_i    (b_q),
    .y_i    (b_q),
    .m_i    (m_q),
    .acc_o  (acc_b)
  );

  assign sts_o.in_trivial = in_trivial;
  assign sts_o.e_last     = (e_q[DataWidth-1:1] == '0);
  assign power_residue_o  = res_q;

endmodule

### rtl/mexp_ctrl.sv
// Controller: sequences base reduction, per-bit multiply/square passes and result handoff.
`timescale 1ns / 1ps

module mexp_ctrl #(
  parameter int unsigned DataWidth = mexp_pkg::DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  mexp_pkg::mexp_sts_t  sts_i,
  output mexp_pkg::mexp_cmd_t  cmd_o
);
  import mexp_pkg::*;

  localparam int unsigned CntW = $clog2(DataWidth);

  typedef enum logic [2:0] {
    S_IDLE, S_RLOAD, S_RED, S_BTAKE, S_MLOAD, S_MUL, S_MTAKE, S_WRITE
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  logic            cnt_last;
  logic            in_xfer;

  assign cnt_last = (cnt_q == CntW'(DataWidth - 1));
  assign in_xfer  = (state_q == S_IDLE) && in_valid_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_in   = in_xfer;
    cmd_o.red_start = (state_q == S_RLOAD);
    cmd_o.step      = (state_q == S_RED) || (state_q == S_MUL);
    cmd_o.red_take  = (state_q == S_BTAKE);
    cmd_o.mul_start = (state_q == S_MLOAD);
    cmd_o.mul_take  = (state_q == S_MTAKE);
    cmd_o.res_load  = (state_q == S_WRITE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= sts_i.in_trivial ? S_WRITE : S_RLOAD;
          end
        end
        S_RLOAD: state_q <= S_RED;
        S_RED: begin
          cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
          if (cnt_last) begin
            state_q <= S_BTAKE;
          end
        end
        S_BTAKE: state_q <= S_MLOAD;
        S_MLOAD: state_q <= S_MUL;
        S_MUL: begin
          cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
          if (cnt_last) begin
            state_q <= S_MTAKE;
          end
        end
        S_MTAKE: state_q <= sts_i.e_last ? S_WRITE : S_MLOAD;
        S_WRITE: begin
          if (cmd_o.res_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_res_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while pending");

  a_res_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |=> out_valid_o)
    else $error("loaded result not presented");

  a_take_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_take |=> (state_q == S_MLOAD || state_q == S_WRITE))
    else $error("bad step after multiply pass");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("accepted a second item while busy");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_RED && state_q != S_MUL) |-> (cnt_q == '0))
    else $error("bit counter left running");

endmodule

### rtl/modular_exponentiation_core.sv
// Top level of the modular exponentiation core (right-to-left square and multiply).
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------------
//   in      | input     | in_valid_i / in_ready_o   | base_value_i, exponent_i, modulus_i
//   out     | output    | out_valid_o / out_ready_i | power_residue_o
//
// One item at a time. Exponent zero or modulus of at most one: the result goes straight to the
// output register. Otherwise the base is first reduced modulo the modulus, then each exponent
// bit up to the top set bit costs one pass of the bit-serial multiply lanes.
// Reset rst_ni is asynchronous, active low, and clears the controller only.
// A finished result waits in the output register; a new transfer is taken meanwhile, and
// its result is held in the datapath until the output register frees up.
`timescale 1ns / 1ps

module modular_exponentiation_core #(
  parameter int unsigned DATA_WIDTH = mexp_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATA_WIDTH-1:0] base_value_i,
  input  logic [DATA_WIDTH-1:0] exponent_i,
  input  logic [DATA_WIDTH-1:0] modulus_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] power_residue_o
);
  import mexp_pkg::*;

  mexp_cmd_t cmd;
  mexp_sts_t sts;

  mexp_ctrl #(.DataWidth(DATA_WIDTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mexp_dp #(.DataWidth(DATA_WIDTH)) u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .base_value_i    (base_value_i),
    .exponent_i      (exponent_i),
    .modulus_i       (modulus_i),
    .power_residue_o (power_residue_o)
  );

endmodule
